// ----- rtl/core/plf_pkg.sv -----
// Shared types, constants and helper functions for the Playfair stream block.
package plf_pkg;

    localparam int unsigned SIDE  = 5;
    localparam int unsigned CELLS = SIDE * SIDE;
    localparam int unsigned IDX_W = 5;
    localparam int unsigned RC_W  = 3;

    localparam logic [IDX_W-1:0] LETTER_I = IDX_W'(8);
    localparam logic [IDX_W-1:0] LETTER_J = IDX_W'(9);
    localparam logic [IDX_W-1:0] LETTER_X = IDX_W'(23);
    localparam logic [IDX_W-1:0] LETTER_LAST = IDX_W'(25);
    localparam logic [IDX_W-1:0] CELL_LIMIT = IDX_W'(CELLS);

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_CASE    = 8'h20;
    localparam logic [6:0] ASCII_A7      = 7'h41;

    typedef enum logic [1:0] {
        OP_KEY_CHAR   = 2'd0,
        OP_KEY_FINISH = 2'd1,
        OP_TEXT_CHAR  = 2'd2,
        OP_TEXT_END   = 2'd3
    } plf_op_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } plf_letter_t;

    typedef struct packed {
        logic             place_en;
        logic [IDX_W-1:0] place_idx;
        logic             pos_rd_en;
        logic [IDX_W-1:0] pos_rd_addr;
        logic             sq_rd_en;
        logic [IDX_W-1:0] sq_rd_addr;
    } plf_store_req_t;

    function automatic plf_letter_t normalize(input logic [7:0] ch);
        plf_letter_t res;
        logic [7:0]  c;
        c = ch;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
        begin
            c = c - ASCII_CASE;
        end
        res.valid = (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z);
        res.idx   = IDX_W'(c - ASCII_UPPER_A);
        if (res.idx == LETTER_J)
        begin
            res.idx = LETTER_I;
        end
        return res;
    endfunction

    function automatic logic [RC_W-1:0] pos_row(input logic [IDX_W-1:0] pos);
        logic [RC_W-1:0] r;
        if (pos >= IDX_W'(4 * SIDE))
            r = RC_W'(4);
        else if (pos >= IDX_W'(3 * SIDE))
            r = RC_W'(3);
        else if (pos >= IDX_W'(2 * SIDE))
            r = RC_W'(2);
        else if (pos >= IDX_W'(SIDE))
            r = RC_W'(1);
        else
            r = RC_W'(0);
        return r;
    endfunction

    function automatic logic [RC_W-1:0] pos_col(input logic [IDX_W-1:0] pos);
        logic [RC_W-1:0]  r;
        logic [IDX_W-1:0] base;
        r    = pos_row(pos);
        base = IDX_W'({r, 2'b00}) + IDX_W'(r);
        return RC_W'(pos - base);
    endfunction

    function automatic logic [RC_W-1:0] shift5(input logic [RC_W-1:0] v, input logic back);
        logic [RC_W:0] s;
        s = {1'b0, v} + (back ? (RC_W+1)'(SIDE - 1) : (RC_W+1)'(1));
        if (s >= (RC_W+1)'(SIDE))
        begin
            s = s - (RC_W+1)'(SIDE);
        end
        return s[RC_W-1:0];
    endfunction

endpackage

// ----- rtl/core/plf_cell_unit.sv -----
// Shared pair-rule unit: yields the square cell of one output letter of a pair.
module plf_cell_unit
    import plf_pkg::*;
(
    input  logic [IDX_W-1:0] pos_a,
    input  logic [IDX_W-1:0] pos_b,
    input  logic             decrypt,
    input  logic             second,
    output logic [IDX_W-1:0] cell_addr
);

    logic [RC_W-1:0] row_a;
    logic [RC_W-1:0] col_a;
    logic [RC_W-1:0] row_b;
    logic [RC_W-1:0] col_b;
    logic [RC_W-1:0] row_self;
    logic [RC_W-1:0] col_self;
    logic [RC_W-1:0] col_other;
    logic [RC_W-1:0] row_out;
    logic [RC_W-1:0] col_out;

    assign row_a = pos_row(pos_a);
    assign col_a = pos_col(pos_a);
    assign row_b = pos_row(pos_b);
    assign col_b = pos_col(pos_b);

    assign row_self  = second ? row_b : row_a;
    assign col_self  = second ? col_b : col_a;
    assign col_other = second ? col_a : col_b;

    always_comb
    begin
        if (row_a == row_b)
        begin
            row_out = row_self;
            col_out = shift5(col_self, decrypt);
        end
        else if (col_a == col_b)
        begin
            row_out = shift5(row_self, decrypt);
            col_out = col_self;
        end
        else
        begin
            row_out = row_self;
            col_out = col_other;
        end
    end

    assign cell_addr = IDX_W'({row_out, 2'b00}) + IDX_W'(row_out) + IDX_W'(col_out);

endmodule

// ----- rtl/core/plf_store.sv -----
// Key square and letter position memories with the used set and fill count.
module plf_store
    import plf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  plf_store_req_t   req,
    output logic [IDX_W-1:0] pos_rd,
    output logic [IDX_W-1:0] sq_rd
);

    logic [IDX_W-1:0] square_mem [CELLS];
    logic [IDX_W-1:0] pos_mem [26];
    logic [25:0]      used_reg;
    logic [25:0]      used_next;
    logic [IDX_W-1:0] fill_reg;
    logic [IDX_W-1:0] fill_next;
    logic [IDX_W-1:0] pos_rd_reg;
    logic [IDX_W-1:0] sq_rd_reg;
    logic             place_ok;

    assign place_ok = req.place_en && !used_reg[req.place_idx] && (fill_reg < CELL_LIMIT);

    always_comb
    begin
        used_next = used_reg;
        fill_next = fill_reg;
        if (place_ok)
        begin
            used_next[req.place_idx] = 1'b1;
            fill_next = fill_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (place_ok)
        begin
            square_mem[fill_reg]    <= req.place_idx;
            pos_mem[req.place_idx] <= fill_reg;
        end
        if (req.pos_rd_en)
        begin
            pos_rd_reg <= pos_mem[req.pos_rd_addr];
        end
        if (req.sq_rd_en)
        begin
            sq_rd_reg <= square_mem[req.sq_rd_addr];
        end
    end

    assign pos_rd = pos_rd_reg;
    assign sq_rd  = sq_rd_reg;

endmodule

// ----- rtl/core/playfair_cipher_stream_top.sv -----
// Playfair cipher stream block: sequencer, pair state and output register.
//
// A key character or a text letter that completes no pair is taken without leaving S_IDLE. A text
// item that completes a pair holds off further input while S_PA, S_PB, S_CALC, S_OX and S_OY run:
// two reads of the position memory, then the shared pair-rule unit and the square memory's single
// read port give one output letter each, each waiting on a free output register. A key finish
// walks the letters A-Z in order while the square fills. Text sent before the key finish is
// dropped; decrypt_mode is sampled as each pair starts.
module playfair_cipher_stream_top
    import plf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // decrypt_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] character
    input  logic [1:0]  s_tuser,        // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // [6:0] out_letter, [7] zero
    output logic        m_tlast         // last_of_text
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FILL = 7'b0000010,
        S_PA   = 7'b0000100,
        S_PB   = 7'b0001000,
        S_CALC = 7'b0010000,
        S_OX   = 7'b0100000,
        S_OY   = 7'b1000000
    } plf_state_t;

    plf_state_t       state_reg;
    plf_state_t       state_next;
    logic             mode_reg;
    logic             key_ready_reg;
    logic             key_ready_next;
    logic [IDX_W-1:0] held_letter_reg;
    logic [IDX_W-1:0] held_letter_next;
    logic             held_valid_reg;
    logic             held_valid_next;
    logic [IDX_W-1:0] pf_reg;
    logic [IDX_W-1:0] pf_next;
    logic             pfv_reg;
    logic             pfv_next;
    logic [IDX_W-1:0] fill_letter_reg;
    logic [IDX_W-1:0] fill_letter_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [6:0]       out_letter_reg;
    logic             out_last_reg;
    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic             last_reg;
    logic             dec_reg;
    logic [IDX_W-1:0] pa_reg;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             out_load_last;
    logic             start_pair;
    logic [IDX_W-1:0] start_a;
    logic [IDX_W-1:0] start_b;
    logic             start_last;
    logic             insert_x;
    plf_letter_t      norm;
    plf_op_t          op;
    plf_store_req_t   store_req;
    logic [IDX_W-1:0] pos_rd;
    logic [IDX_W-1:0] sq_rd;
    logic [IDX_W-1:0] cell_addr;
    logic [6:0]       letter_ascii;

    assign op       = plf_op_t'(s_tuser);
    assign norm     = normalize(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign insert_x = !mode_reg && held_valid_reg && (held_letter_reg == norm.idx);
    assign letter_ascii = ASCII_A7 + 7'(sq_rd);

    plf_cell_unit u_cell (
        .pos_a     (pa_reg),
        .pos_b     (pos_rd),
        .decrypt   (dec_reg),
        .second    (state_reg == S_OX),
        .cell_addr (cell_addr)
    );

    plf_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (store_req),
        .pos_rd (pos_rd),
        .sq_rd  (sq_rd)
    );

    always_comb
    begin
        state_next       = state_reg;
        key_ready_next   = key_ready_reg;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        pf_next          = pf_reg;
        pfv_next         = pfv_reg;
        fill_letter_next = fill_letter_reg;
        start_pair       = 1'b0;
        start_a          = pf_reg;
        start_b          = norm.idx;
        start_last       = 1'b0;
        out_load         = 1'b0;
        out_load_last    = 1'b0;
        store_req        = '0;
        store_req.place_idx   = norm.idx;
        store_req.pos_rd_addr = a_reg;
        store_req.sq_rd_addr  = cell_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_KEY_CHAR:
                        begin
                            store_req.place_en = !key_ready_reg && norm.valid;
                        end
                        OP_KEY_FINISH:
                        begin
                            if (!key_ready_reg)
                            begin
                                fill_letter_next = '0;
                                state_next       = S_FILL;
                            end
                        end
                        OP_TEXT_CHAR:
                        begin
                            if (key_ready_reg && norm.valid)
                            begin
                                if (insert_x)
                                begin
                                    start_pair = 1'b1;
                                    if (pfv_reg)
                                    begin
                                        start_b  = LETTER_X;
                                        pf_next  = norm.idx;
                                        pfv_next = 1'b1;
                                    end
                                    else
                                    begin
                                        start_a  = LETTER_X;
                                        pfv_next = 1'b0;
                                    end
                                end
                                else if (pfv_reg)
                                begin
                                    start_pair = 1'b1;
                                    pfv_next   = 1'b0;
                                end
                                else
                                begin
                                    pf_next  = norm.idx;
                                    pfv_next = 1'b1;
                                end
                                held_letter_next = norm.idx;
                                held_valid_next  = 1'b1;
                            end
                        end
                        OP_TEXT_END:
                        begin
                            if (key_ready_reg)
                            begin
                                if (pfv_reg)
                                begin
                                    start_pair = 1'b1;
                                    start_b    = LETTER_X;
                                    start_last = 1'b1;
                                end
                                held_valid_next = 1'b0;
                                pfv_next        = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (start_pair)
                    begin
                        state_next = S_PA;
                    end
                end
            end
            S_FILL:
            begin
                store_req.place_en  = (fill_letter_reg != LETTER_J);
                store_req.place_idx = fill_letter_reg;
                fill_letter_next    = fill_letter_reg + IDX_W'(1);
                if (fill_letter_reg == LETTER_LAST)
                begin
                    key_ready_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PA:
            begin
                store_req.pos_rd_en   = 1'b1;
                store_req.pos_rd_addr = a_reg;
                state_next            = S_PB;
            end
            S_PB:
            begin
                store_req.pos_rd_en   = 1'b1;
                store_req.pos_rd_addr = b_reg;
                state_next            = S_CALC;
            end
            S_CALC:
            begin
                store_req.sq_rd_en = 1'b1;
                state_next         = S_OX;
            end
            S_OX:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    store_req.sq_rd_en = 1'b1;
                    state_next         = S_OY;
                end
            end
            S_OY:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_load_last = last_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= 1'b0;
            key_ready_reg   <= 1'b0;
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            pf_reg          <= '0;
            pfv_reg         <= 1'b0;
            fill_letter_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            key_ready_reg   <= key_ready_next;
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            pf_reg          <= pf_next;
            pfv_reg         <= pfv_next;
            fill_letter_reg <= fill_letter_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_pair && accept)
        begin
            a_reg    <= start_a;
            b_reg    <= start_b;
            last_reg <= start_last;
            dec_reg  <= mode_reg;
        end
        if (state_reg == S_PB)
        begin
            pa_reg <= pos_rd;
        end
        if (out_load)
        begin
            out_letter_reg <= letter_ascii;
            out_last_reg   <= out_load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_letter_reg};
    assign m_tlast  = out_last_reg;

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_fill_sets_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && fill_letter_reg == LETTER_LAST) |=> key_ready_reg)
        else $error("key not ready after square fill");

    a_key_from_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_ready_reg) |-> $past(state_reg == S_FILL))
        else $error("key ready raised outside square fill");

    a_pair_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OY && out_free) |=> (s_tready && m_tvalid))
        else $error("pair end did not return to idle with a result");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the Playfair stream block: directed key and text, then random items.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import plf_pkg::*;

    localparam int LIMIT        = 300000;
    localparam int SETTLE       = 40;
    localparam int CHOKE_CYCLES = 400;
    localparam int ITEM_TARGET  = 900;
    localparam int TAIL_START   = 800;
    localparam int DIR_ROWS     = 30;

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
    } out_letter_t;

    typedef struct packed {
        logic       mode;
        plf_op_t    op;
        logic [7:0] ch;
        logic       typed;
        logic [1:0] n;
        logic [6:0] l0;
        logic [6:0] l1;
        logic       last;
    } dir_step_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    playfair_cipher_stream_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic [4:0]  sq_letter [CELLS];
    logic [4:0]  sq_cell [26];
    logic [25:0] used_letters = '0;
    int          fill = 0;
    bit          key_done = 1'b0;
    logic [4:0]  prev_letter = '0;
    bit          prev_valid = 1'b0;
    logic [4:0]  pend_letter = '0;
    bit          pend_valid = 1'b0;
    bit          mode_dec = 1'b0;

    out_letter_t letters_due [$];
    out_letter_t step_out [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  tail = 1'b0;
    bit  choke_now = 1'b0;
    int  send_idle_pct = 20;
    int  ready_idle_pct = 20;

    dir_step_t dir_steps [DIR_ROWS] = '{
        '{1'b0, OP_TEXT_CHAR,   8'h41, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_TEXT_END,    8'h00, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "p",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "l",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "a",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "y",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "f",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "I",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "R",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    " ",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "e",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "x",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "m",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_FINISH,  8'h00, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_CHAR,    "Z",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_KEY_FINISH,  8'hFF, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_TEXT_CHAR,   "H",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_TEXT_CHAR,   "i",   1'b1, 2'd2, 7'h42, 7'h4D, 1'b0},
        '{1'b0, OP_TEXT_CHAR,   8'hFF, 1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_TEXT_CHAR,   "e",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_TEXT_CHAR,   "E",   1'b0, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_TEXT_CHAR,   "z",   1'b0, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_TEXT_CHAR,   "Q",   1'b0, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b0, OP_TEXT_END,    8'h00, 1'b0, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b1, OP_TEXT_CHAR,   "b",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b1, OP_TEXT_CHAR,   "M",   1'b1, 2'd2, 7'h48, 7'h49, 1'b0},
        '{1'b1, OP_TEXT_CHAR,   "E",   1'b1, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b1, OP_TEXT_CHAR,   "E",   1'b0, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b1, OP_TEXT_CHAR,   "j",   1'b0, 2'd0, 7'h00, 7'h00, 1'b0},
        '{1'b1, OP_TEXT_END,    8'hFF, 1'b0, 2'd0, 7'h00, 7'h00, 1'b0}
    };

    function automatic bit fold_letter(input logic [7:0] ch, output logic [4:0] idx);
        logic [7:0] c;
        c   = ch;
        idx = '0;
        if (c >= "a" && c <= "z")
        begin
            c = c - 8'h20;
        end
        if (c < "A" || c > "Z")
        begin
            return 1'b0;
        end
        idx = 5'(c - "A");
        if (idx == LETTER_J)
        begin
            idx = LETTER_I;
        end
        return 1'b1;
    endfunction

    task automatic place_letter(input logic [4:0] idx);
        if (used_letters[idx] || fill >= CELLS)
        begin
            return;
        end
        sq_letter[fill]   = idx;
        sq_cell[idx]      = 5'(fill);
        used_letters[idx] = 1'b1;
        fill++;
    endtask

    function automatic logic [6:0] square_char(input int unsigned r, input int unsigned c);
        return 7'h41 + 7'(sq_letter[(r % SIDE) * SIDE + (c % SIDE)]);
    endfunction

    task automatic map_pair(input logic [4:0] a, input logic [4:0] b, input logic pad_end);
        int unsigned pa, pb, r1, c1, r2, c2, sh;
        out_letter_t x, y;
        pa = sq_cell[a];
        pb = sq_cell[b];
        r1 = pa / SIDE;
        c1 = pa % SIDE;
        r2 = pb / SIDE;
        c2 = pb % SIDE;
        sh = mode_dec ? SIDE - 1 : 1;
        if (r1 == r2)
        begin
            x.letter = square_char(r1, c1 + sh);
            y.letter = square_char(r2, c2 + sh);
        end
        else if (c1 == c2)
        begin
            x.letter = square_char(r1 + sh, c1);
            y.letter = square_char(r2 + sh, c2);
        end
        else
        begin
            x.letter = square_char(r1, c2);
            y.letter = square_char(r2, c1);
        end
        x.last = 1'b0;
        y.last = pad_end;
        step_out.push_back(x);
        step_out.push_back(y);
    endtask

    task automatic pair_letter(input logic [4:0] idx, input logic pad_end);
        if (pend_valid)
        begin
            map_pair(pend_letter, idx, pad_end);
            pend_valid = 1'b0;
        end
        else
        begin
            pend_letter = idx;
            pend_valid  = 1'b1;
        end
    endtask

    task automatic encipher_item(input plf_op_t op, input logic [7:0] ch);
        logic [4:0] idx;
        step_out.delete();
        case (op)
            OP_KEY_CHAR:
            begin
                if (!key_done && fold_letter(ch, idx))
                begin
                    place_letter(idx);
                end
            end
            OP_KEY_FINISH:
            begin
                if (!key_done)
                begin
                    for (int l = 0; l < 26; l++)
                    begin
                        if (5'(l) != LETTER_J)
                        begin
                            place_letter(5'(l));
                        end
                    end
                    key_done = 1'b1;
                end
            end
            OP_TEXT_CHAR:
            begin
                if (key_done && fold_letter(ch, idx))
                begin
                    if (!mode_dec && prev_valid && prev_letter == idx)
                    begin
                        pair_letter(LETTER_X, 1'b0);
                    end
                    pair_letter(idx, 1'b0);
                    prev_letter = idx;
                    prev_valid  = 1'b1;
                end
            end
            default:
            begin
                if (key_done)
                begin
                    if (pend_valid)
                    begin
                        pair_letter(LETTER_X, 1'b1);
                    end
                    prev_valid = 1'b0;
                    pend_valid = 1'b0;
                end
            end
        endcase
    endtask

    task automatic send_item(input plf_op_t op, input logic [7:0] ch);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        encipher_item(op, ch);
    endtask

    task automatic queue_predicted();
        foreach (step_out[i])
        begin
            letters_due.push_back(step_out[i]);
        end
    endtask

    task automatic sender_gap();
        if (!tail && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (letters_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_dec = value;
    endtask

    task automatic note_mismatch(input string what, input out_letter_t due);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch (%s) at cycle %0d: expected letter %h last %b, got data %h last %b",
                     what, cycle_count, due.letter, due.last, m_tdata, m_tlast);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still due", LIMIT, letters_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_letter_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (letters_due.size() == 0)
            begin
                due = '0;
                note_mismatch("unexpected item", due);
            end
            else
            begin
                due = letters_due.pop_front();
                if (m_tdata != {1'b0, due.letter} || m_tlast != due.last)
                begin
                    note_mismatch("wrong field", due);
                end
            end
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (choke_now)
            begin
                m_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_now = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!tail && $urandom_range(0, 99) < ready_idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int         counted;
        int         phase_left;
        int         phase_no;
        int         r;
        int         rnd_prev;
        int         l;
        plf_op_t    op;
        logic [7:0] ch;
        out_letter_t typed_res;

        counted  = 0;
        phase_no = 0;
        rnd_prev = 0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= OP_KEY_CHAR;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        foreach (dir_steps[i])
        begin
            if (dir_steps[i].mode != mode_dec)
            begin
                drain_and_settle();
                write_mode(dir_steps[i].mode);
            end
            sender_gap();
            send_item(dir_steps[i].op, dir_steps[i].ch);
            if (dir_steps[i].typed)
            begin
                for (int j = 0; j < int'(dir_steps[i].n); j++)
                begin
                    typed_res.letter = (j == 0) ? dir_steps[i].l0 : dir_steps[i].l1;
                    typed_res.last   = (j == 1) ? dir_steps[i].last : 1'b0;
                    letters_due.push_back(typed_res);
                end
            end
            else
            begin
                queue_predicted();
            end
        end

        phase_left = 0;
        while (counted < ITEM_TARGET)
        begin
            if (phase_left == 0 && !tail)
            begin
                drain_and_settle();
                write_mode(1'($urandom_range(0, 1)));
                phase_no++;
                phase_left = $urandom_range(40, 150);
                case ($urandom_range(0, 2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 10;
                    default: send_idle_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: ready_idle_pct = 0;
                    1: ready_idle_pct = 15;
                    default: ready_idle_pct = 50;
                endcase
                if (phase_no == 2)
                begin
                    choke_now = 1'b1;
                end
            end
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                op = OP_KEY_CHAR;
                ch = 8'($urandom_range(0, 255));
            end
            else if (r < 5)
            begin
                op = OP_KEY_FINISH;
                ch = 8'($urandom_range(0, 255));
            end
            else if (r < 17)
            begin
                op = OP_TEXT_END;
                ch = 8'($urandom_range(0, 255));
            end
            else if (r < 25)
            begin
                op = OP_TEXT_CHAR;
                ch = 8'($urandom_range(0, 255));
            end
            else
            begin
                op = OP_TEXT_CHAR;
                l  = ($urandom_range(0, 99) < 20) ? rnd_prev : $urandom_range(0, 25);
                rnd_prev = l;
                ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(l);
            end
            counted++;
            if (counted >= TAIL_START)
            begin
                tail = 1'b1;
            end
            sender_gap();
            send_item(op, ch);
            queue_predicted();
            phase_left--;
        end

        drain_and_settle();
        if (mismatches == 0 && letters_due.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
